FILE: design/pcmp_pkg.sv
// pcmp_pkg: shared types, codes, constants and rounding helpers for the
// point cloud mask projector. No dependencies; used by pcmp_ctrl, pcmp_datapath and the core.
`default_nettype none

package pcmp_pkg;

  // input transaction command codes (carried in tuser)
  localparam logic [2:0] CMD_POINT      = 3'd0;
  localparam logic [2:0] CMD_SET_LANE   = 3'd1;
  localparam logic [2:0] CMD_CLR_LANE   = 3'd2;
  localparam logic [2:0] CMD_CLR_BOXES  = 3'd3;
  localparam logic [2:0] CMD_ADD_BOX    = 3'd4;
  localparam logic [2:0] CMD_POSE       = 3'd5;

  // configuration register indexes
  localparam logic [2:0] CFG_FOCAL_X      = 3'd0;
  localparam logic [2:0] CFG_FOCAL_Y      = 3'd1;
  localparam logic [2:0] CFG_CENTER_X     = 3'd2;
  localparam logic [2:0] CFG_CENTER_Y     = 3'd3;
  localparam logic [2:0] CFG_IMAGE_WIDTH  = 3'd4;
  localparam logic [2:0] CFG_IMAGE_HEIGHT = 3'd5;
  localparam logic [2:0] CFG_LANE_WIDTH   = 3'd6;

  localparam logic [18:0] LANE_WIDTH_RST = 19'd22938;

  // quotient bits of the pixel division
  localparam int DIV_W = 46;
  localparam logic [5:0] DIV_STEPS = 6'd46;

  localparam logic signed [63:0] COS_Q30   = 64'sd973140718;
  localparam logic signed [63:0] SIN_Q30   = 64'sd453782599;
  localparam logic signed [63:0] ONE_Q30   = 64'sd1073741824;
  localparam logic signed [63:0] HEIGHT_Q16 = 64'sd19661;
  localparam logic signed [31:0] DEPTH_MIN_Q16 = 32'sd3276;
  localparam logic signed [34:0] XB_MIN_Q16 = 35'sd9831;
  localparam logic signed [34:0] XB_MAX_Q16 = 35'sd65536;
  localparam logic [33:0] MARGIN2_Q16 = 34'd13108;

  localparam logic [3:0] MAC_LAST = 4'd8;

  typedef struct packed {
    logic accept;
    logic dispatch;
    logic mul;
    logic sum;
    logic check;
    logic mac_start;
    logic pose_fin;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_point;
    logic is_pose;
    logic gate_ok;
    logic div_done;
    logic in_img;
    logic scan_done;
    logic keep;
    logic pose_loaded;
    logic mac_last;
    logic out_free;
  } dp_stat_t;

  // divide by 2^30, ties away from zero
  function automatic logic signed [63:0] rnd30(input logic signed [63:0] v);
    logic [63:0] m;
    logic [63:0] r;
    m = v[63] ? 64'(-v) : 64'(v);
    r = (m + 64'd536870912) >> 30;
    return v[63] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // row and column of a 3x3 matrix entry
  function automatic logic [1:0] k_row(input logic [3:0] k);
    case (k)
      4'd0, 4'd1, 4'd2: return 2'd0;
      4'd3, 4'd4, 4'd5: return 2'd1;
      4'd6, 4'd7, 4'd8: return 2'd2;
      default: return 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] k_col(input logic [3:0] k);
    case (k)
      4'd0, 4'd3, 4'd6: return 2'd0;
      4'd1, 4'd4, 4'd7: return 2'd1;
      4'd2, 4'd5, 4'd8: return 2'd2;
      default: return 2'd0;
    endcase
  endfunction

endpackage

`default_nettype wire

FILE: design/pcmp_ram.sv
// pcmp_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
`default_nettype none

module pcmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: design/pcmp_ctrl.sv
// pcmp_ctrl: sequencing state machine of the projector.
// Depends on pcmp_pkg for the command and status structs.
`default_nettype none

module pcmp_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output pcmp_pkg::dp_cmd_t       cmd,
  input  wire pcmp_pkg::dp_stat_t stat
);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_DISP     = 11'b00000000010,
    S_MUL      = 11'b00000000100,
    S_SUM      = 11'b00000001000,
    S_DIV      = 11'b00000010000,
    S_CHECK    = 11'b00000100000,
    S_SCAN     = 11'b00001000000,
    S_CLASS    = 11'b00010000000,
    S_MAC      = 11'b00100000000,
    S_POSE_FIN = 11'b01000000000,
    S_OUT      = 11'b10000000000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        cmd.dispatch = 1'b1;
        if (stat.is_point) begin
          state_next = stat.gate_ok ? S_MUL : S_IDLE;
        end else if (stat.is_pose) begin
          cmd.mac_start = 1'b1;
          state_next    = S_MAC;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = stat.in_img ? S_SCAN : S_IDLE;
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          state_next = S_CLASS;
        end
      end
      S_CLASS: begin
        if (!stat.keep) begin
          state_next = S_IDLE;
        end else if (stat.pose_loaded) begin
          cmd.mac_start = 1'b1;
          state_next    = S_MAC;
        end else begin
          state_next = S_OUT;
        end
      end
      S_MAC: begin
        if (stat.mac_last) begin
          state_next = stat.is_pose ? S_POSE_FIN : S_OUT;
        end
      end
      S_POSE_FIN: begin
        cmd.pose_fin = 1'b1;
        state_next   = S_IDLE;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/pcmp_datapath.sv
// pcmp_datapath: registers, multipliers, divider, mask and box stores, output register.
// Depends on pcmp_pkg and pcmp_ram.
`default_nettype none

module pcmp_datapath #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_BOXES  = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [279:0]       in_data,
  input  wire logic [2:0]         in_user,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [27:0]        cfg_data,
  input  wire pcmp_pkg::dp_cmd_t  cmd,
  output pcmp_pkg::dp_stat_t      stat,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [191:0]            out_data,
  output logic [2:0]              out_user
);

  localparam int AW   = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int BW   = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CNTW = $clog2(MAX_BOXES + 1);
  localparam logic [12:0] MAXW = 13'(MAX_WIDTH);
  localparam logic [12:0] MAXH = 13'(MAX_HEIGHT);
  localparam logic [CNTW-1:0] BOX_LIMIT = CNTW'(MAX_BOXES);

  // configuration
  logic [27:0] focal_x, focal_y, center_x, center_y;
  logic [10:0] image_width, image_height;
  logic [18:0] lane_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x      <= '0;
      focal_y      <= '0;
      center_x     <= '0;
      center_y     <= '0;
      image_width  <= '0;
      image_height <= '0;
      lane_width   <= pcmp_pkg::LANE_WIDTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pcmp_pkg::CFG_FOCAL_X:      focal_x      <= cfg_data;
        pcmp_pkg::CFG_FOCAL_Y:      focal_y      <= cfg_data;
        pcmp_pkg::CFG_CENTER_X:     center_x     <= cfg_data;
        pcmp_pkg::CFG_CENTER_Y:     center_y     <= cfg_data;
        pcmp_pkg::CFG_IMAGE_WIDTH:  image_width  <= cfg_data[10:0];
        pcmp_pkg::CFG_IMAGE_HEIGHT: image_height <= cfg_data[10:0];
        pcmp_pkg::CFG_LANE_WIDTH:   lane_width   <= cfg_data[18:0];
        default: ;
      endcase
    end
  end

  // input transaction register
  logic [2:0]         in_cmd;
  logic signed [31:0] in_x, in_y, in_z, qx, qy, qz, qw;
  logic [13:0]        in_col, in_row, in_col_end, in_row_end;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      in_cmd     <= in_user;
      in_x       <= in_data[31:0];
      in_y       <= in_data[63:32];
      in_z       <= in_data[95:64];
      qx         <= in_data[127:96];
      qy         <= in_data[159:128];
      qz         <= in_data[191:160];
      qw         <= in_data[223:192];
      in_col     <= in_data[237:224];
      in_row     <= in_data[251:238];
      in_col_end <= in_data[265:252];
      in_row_end <= in_data[279:266];
    end
  end

  logic is_pose;
  assign is_pose = (in_cmd == pcmp_pkg::CMD_POSE);

  // lane mask store and box list
  logic            mask_loaded, pose_loaded;
  logic [CNTW-1:0] box_count;
  logic            wr_in_range, mask_we, mask_wbit, mask_rbit, box_we;
  logic [AW-1:0]   mask_waddr, mask_raddr;
  logic [55:0]     box_rdata;
  logic [CNTW-1:0] scan_idx;

  assign wr_in_range = !in_col[13] && !in_row[13] && (in_col[12:0] < MAXW) &&
                       (in_row[12:0] < MAXH);
  assign mask_we    = cmd.dispatch && wr_in_range &&
                      ((in_cmd == pcmp_pkg::CMD_SET_LANE) || (in_cmd == pcmp_pkg::CMD_CLR_LANE));
  assign mask_wbit  = (in_cmd == pcmp_pkg::CMD_SET_LANE);
  assign mask_waddr = AW'(in_row[12:0]) * AW'(MAX_WIDTH) + AW'(in_col[12:0]);
  assign box_we     = cmd.dispatch && (in_cmd == pcmp_pkg::CMD_ADD_BOX) &&
                      (box_count < BOX_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_loaded <= 1'b0;
      box_count   <= '0;
    end else begin
      if (mask_we) begin
        mask_loaded <= 1'b1;
      end
      if (cmd.dispatch && (in_cmd == pcmp_pkg::CMD_CLR_BOXES)) begin
        box_count <= '0;
      end else if (box_we) begin
        box_count <= box_count + 1'b1;
      end
    end
  end

  pcmp_ram #(.WIDTH(1), .DEPTH(MAX_WIDTH * MAX_HEIGHT)) u_mask_ram (
    .clk   (clk),
    .we    (mask_we),
    .waddr (mask_waddr),
    .wdata (mask_wbit),
    .raddr (mask_raddr),
    .rdata (mask_rbit)
  );

  pcmp_ram #(.WIDTH(56), .DEPTH(MAX_BOXES)) u_box_ram (
    .clk   (clk),
    .we    (box_we),
    .waddr (box_count[BW-1:0]),
    .wdata ({in_row_end, in_col_end, in_row, in_col}),
    .raddr (scan_idx[BW-1:0]),
    .rdata (box_rdata)
  );

  // products of the projection and pitch rotation
  logic signed [63:0] prod_ux, prod_uc, prod_vy, prod_vc;
  logic signed [63:0] prod_cz, prod_sy, prod_sz, prod_cy;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_ux <= 64'($signed({1'b0, focal_x})) * 64'(in_x);
      prod_uc <= 64'($signed({1'b0, center_x})) * 64'(in_z);
      prod_vy <= 64'($signed({1'b0, focal_y})) * 64'(in_y);
      prod_vc <= 64'($signed({1'b0, center_y})) * 64'(in_z);
      prod_cz <= pcmp_pkg::COS_Q30 * 64'(in_z);
      prod_sy <= pcmp_pkg::SIN_Q30 * 64'(in_y);
      prod_sz <= pcmp_pkg::SIN_Q30 * 64'(in_z);
      prod_cy <= pcmp_pkg::COS_Q30 * 64'(in_y);
    end
  end

  // numerators: (2|n| + z*2^16) >> 17 divided by z gives the rounded pixel
  logic signed [63:0] num_u, num_v;
  logic [63:0]        mag_u, mag_v, z_shift, t_u, t_v;

  always_comb begin
    num_u   = prod_ux + prod_uc;
    num_v   = prod_vy + prod_vc;
    mag_u   = num_u[63] ? 64'(-num_u) : 64'(num_u);
    mag_v   = num_v[63] ? 64'(-num_v) : 64'(num_v);
    z_shift = 64'($unsigned(in_z)) << 16;
    t_u     = {mag_u[62:0], 1'b0} + z_shift;
    t_v     = {mag_v[62:0], 1'b0} + z_shift;
  end

  logic                      neg_u, neg_v;
  logic signed [34:0]        xb_q, zb_q;
  logic [pcmp_pkg::DIV_W-1:0] quo_u, quo_v;
  logic [30:0]               rem_u, rem_v;
  logic [5:0]                div_cnt;
  logic [31:0]               trial_u, trial_v;

  assign trial_u = {rem_u, quo_u[pcmp_pkg::DIV_W-1]} - {1'b0, in_z[30:0]};
  assign trial_v = {rem_v, quo_v[pcmp_pkg::DIV_W-1]} - {1'b0, in_z[30:0]};

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      neg_u <= num_u[63];
      neg_v <= num_v[63];
      xb_q  <= 35'(pcmp_pkg::rnd30(prod_cz - prod_sy));
      zb_q  <= 35'(pcmp_pkg::rnd30(-prod_sz - prod_cy) + pcmp_pkg::HEIGHT_Q16);
    end
  end

  // restoring divider, one quotient bit per cycle on each axis
  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      quo_u <= t_u[62:17];
      quo_v <= t_v[62:17];
      rem_u <= '0;
      rem_v <= '0;
    end else if (div_cnt != '0) begin
      if (!trial_u[31]) begin
        rem_u <= trial_u[30:0];
        quo_u <= {quo_u[pcmp_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_u <= {rem_u[29:0], quo_u[pcmp_pkg::DIV_W-1]};
        quo_u <= {quo_u[pcmp_pkg::DIV_W-2:0], 1'b0};
      end
      if (!trial_v[31]) begin
        rem_v <= trial_v[30:0];
        quo_v <= {quo_v[pcmp_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_v <= {rem_v[29:0], quo_v[pcmp_pkg::DIV_W-1]};
        quo_v <= {quo_v[pcmp_pkg::DIV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.sum) begin
      div_cnt <= pcmp_pkg::DIV_STEPS;
    end else if (div_cnt != '0) begin
      div_cnt <= div_cnt - 1'b1;
    end
  end

  // image bounds
  logic [12:0] lim_w, lim_h;
  logic        in_img;

  assign lim_w  = (13'(image_width) < MAXW) ? 13'(image_width) : MAXW;
  assign lim_h  = (13'(image_height) < MAXH) ? 13'(image_height) : MAXH;
  assign in_img = !(neg_u && (quo_u != '0)) && !(neg_v && (quo_v != '0)) &&
                  (quo_u < pcmp_pkg::DIV_W'(lim_w)) && (quo_v < pcmp_pkg::DIV_W'(lim_h));
  assign mask_raddr = AW'(quo_v[12:0]) * AW'(MAX_WIDTH) + AW'(quo_u[12:0]);

  // box scan: one box read per cycle, compare on the registered data
  logic               scan_iss, scan_pend, lane_cap, lane_f, obj_f, box_hit;
  logic signed [15:0] u_s, v_s;

  assign u_s = $signed({3'b000, quo_u[12:0]});
  assign v_s = $signed({3'b000, quo_v[12:0]});
  assign box_hit = (u_s >= 16'($signed(box_rdata[13:0]))) &&
                   (v_s >= 16'($signed(box_rdata[27:14]))) &&
                   (u_s <= 16'($signed(box_rdata[41:28]))) &&
                   (v_s <= 16'($signed(box_rdata[55:42])));

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_iss  <= 1'b0;
      scan_pend <= 1'b0;
      lane_cap  <= 1'b0;
    end else begin
      lane_cap <= cmd.check;
      if (cmd.check) begin
        scan_iss  <= (box_count != '0);
        scan_pend <= 1'b0;
      end else begin
        scan_pend <= scan_iss;
        if (scan_iss && (scan_idx + 1'b1 == box_count)) begin
          scan_iss <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      scan_idx <= '0;
      obj_f    <= 1'b0;
    end else begin
      if (scan_iss) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (scan_pend && box_hit) begin
        obj_f <= 1'b1;
      end
    end
    if (lane_cap) begin
      lane_f <= mask_rbit;
    end
  end

  // saturated base frame point
  logic signed [31:0] base_x, base_y, base_z;

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      base_x <= pcmp_pkg::sat32(64'(xb_q));
      base_y <= pcmp_pkg::sat32(-64'(in_x));
      base_z <= pcmp_pkg::sat32(64'(zb_q));
    end
  end

  // range filters
  logic [32:0] abs_x;
  logic        lane_ok, keep;

  assign abs_x   = in_x[31] ? 33'(-34'(in_x)) : 33'(in_x);
  assign lane_ok = (xb_q >= pcmp_pkg::XB_MIN_Q16) && (xb_q <= pcmp_pkg::XB_MAX_Q16) &&
                   ({abs_x, 1'b0} <= 34'(lane_width) + pcmp_pkg::MARGIN2_Q16);
  assign keep    = (lane_f || obj_f) && (!lane_f || lane_ok) &&
                   (!obj_f || (xb_q <= pcmp_pkg::XB_MAX_Q16));

  // shared multiplier for quaternion products and the map rotation
  logic               mac_iss, con_v;
  logic [3:0]         iss_k, con_k;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod_m, prod_r;
  logic signed [31:0] rot [9];
  logic signed [31:0] trans [3];
  logic signed [33:0] pq [9];
  logic signed [35:0] acc, acc_n;
  logic signed [31:0] map_v [3];
  logic signed [31:0] base_sel;

  always_comb begin
    case (k_col_iss())
      2'd0:    base_sel = base_x;
      2'd1:    base_sel = base_y;
      default: base_sel = base_z;
    endcase
  end

  function automatic logic [1:0] k_col_iss();
    return pcmp_pkg::k_col(iss_k);
  endfunction

  always_comb begin
    mul_a = rot[iss_k];
    mul_b = base_sel;
    if (is_pose) begin
      case (iss_k)
        4'd0:    begin mul_a = qx; mul_b = qx; end
        4'd1:    begin mul_a = qy; mul_b = qy; end
        4'd2:    begin mul_a = qz; mul_b = qz; end
        4'd3:    begin mul_a = qx; mul_b = qy; end
        4'd4:    begin mul_a = qx; mul_b = qz; end
        4'd5:    begin mul_a = qy; mul_b = qz; end
        4'd6:    begin mul_a = qw; mul_b = qx; end
        4'd7:    begin mul_a = qw; mul_b = qy; end
        default: begin mul_a = qw; mul_b = qz; end
      endcase
    end
  end

  assign prod_r = pcmp_pkg::rnd30(prod_m);
  assign acc_n  = ((pcmp_pkg::k_col(con_k) == 2'd0) ? 36'sd0 : acc) + 36'(prod_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      mac_iss <= 1'b0;
      con_v   <= 1'b0;
    end else if (cmd.mac_start) begin
      mac_iss <= 1'b1;
      con_v   <= 1'b0;
    end else begin
      con_v <= mac_iss;
      if (mac_iss && (iss_k == pcmp_pkg::MAC_LAST)) begin
        mac_iss <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mac_start) begin
      iss_k <= '0;
    end else if (mac_iss) begin
      iss_k  <= iss_k + 1'b1;
      prod_m <= 64'(mul_a) * 64'(mul_b);
    end
    con_k <= iss_k;
    if (con_v) begin
      if (is_pose) begin
        pq[con_k] <= 34'(prod_r);
      end else begin
        acc <= acc_n;
        if (pcmp_pkg::k_col(con_k) == 2'd2) begin
          map_v[pcmp_pkg::k_row(con_k)] <=
            pcmp_pkg::sat32(64'(acc_n) + 64'(trans[pcmp_pkg::k_row(con_k)]));
        end
      end
    end
  end

  // rotation matrix from the quaternion products (xx yy zz xy xz yz wx wy wz)
  always_ff @(posedge clk) begin
    if (cmd.pose_fin) begin
      rot[0]   <= pcmp_pkg::sat32(pcmp_pkg::ONE_Q30 - 2 * (64'(pq[1]) + 64'(pq[2])));
      rot[1]   <= pcmp_pkg::sat32(2 * (64'(pq[3]) - 64'(pq[8])));
      rot[2]   <= pcmp_pkg::sat32(2 * (64'(pq[4]) + 64'(pq[7])));
      rot[3]   <= pcmp_pkg::sat32(2 * (64'(pq[3]) + 64'(pq[8])));
      rot[4]   <= pcmp_pkg::sat32(pcmp_pkg::ONE_Q30 - 2 * (64'(pq[0]) + 64'(pq[2])));
      rot[5]   <= pcmp_pkg::sat32(2 * (64'(pq[5]) - 64'(pq[6])));
      rot[6]   <= pcmp_pkg::sat32(2 * (64'(pq[4]) - 64'(pq[7])));
      rot[7]   <= pcmp_pkg::sat32(2 * (64'(pq[5]) + 64'(pq[6])));
      rot[8]   <= pcmp_pkg::sat32(pcmp_pkg::ONE_Q30 - 2 * (64'(pq[0]) + 64'(pq[1])));
      trans[0] <= in_x;
      trans[1] <= in_y;
      trans[2] <= in_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pose_loaded <= 1'b0;
    end else if (cmd.pose_fin) begin
      pose_loaded <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_user <= {pose_loaded, obj_f, lane_f};
      out_data[95:0] <= {base_z, base_y, base_x};
      out_data[191:96] <= pose_loaded ? {map_v[2], map_v[1], map_v[0]} : 96'd0;
    end
  end

  always_comb begin
    stat             = '0;
    stat.is_point    = (in_cmd == pcmp_pkg::CMD_POINT);
    stat.is_pose     = is_pose;
    stat.gate_ok     = mask_loaded && (focal_x != '0) && (in_z > pcmp_pkg::DEPTH_MIN_Q16);
    stat.div_done    = (div_cnt == '0);
    stat.in_img      = in_img;
    stat.scan_done   = !scan_iss && !scan_pend;
    stat.keep        = keep;
    stat.pose_loaded = pose_loaded;
    stat.mac_last    = con_v && (con_k == pcmp_pkg::MAC_LAST);
    stat.out_free    = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

FILE: design/point_cloud_mask_projector_core.sv
// Point cloud mask projector: projects camera points onto a lane mask and box list.
// Channels: s_* takes commands and points, m_* gives classified points.
// Configuration: cfg_we/cfg_index/cfg_data write a register.
// A point runs from acceptance to the output register through dispatch, the
// products, the 46-step restoring divider for the pixel position and the box
// scan (one box read per cycle from the box RAM); with a pose loaded the map
// transform then runs on the shared multiplier. Mask, box and clear commands
// finish at dispatch; a pose load runs its products on the shared multiplier.
// One transaction is in work at a time; s_tready is high only when idle.
// Points that are rejected give no output transaction.
// The result sits in an output register, so the next input is taken while
// a finished result waits; a stalled m_tready holds m_tdata and m_tuser and
// blocks only a later point that reaches its own output step.
// Reset (rst, synchronous) clears control state, box count, mask-loaded and
// pose-loaded flags, resets the config registers; mask and box contents stay undefined.
// Depends on pcmp_pkg, pcmp_ctrl, pcmp_datapath and pcmp_ram.
`default_nettype none

module point_cloud_mask_projector_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_BOXES  = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // coord_x, coord_y, coord_z, quat_x, quat_y, quat_z, quat_w, col, row, col_end, row_end
  input  wire logic [279:0] s_tdata,
  // command
  input  wire logic [2:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // base_x, base_y, base_z, map_x, map_y, map_z
  output logic [191:0]      m_tdata,
  // lane_flag, object_flag, map_valid
  output logic [2:0]        m_tuser,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [27:0]  cfg_data
);

  pcmp_pkg::dp_cmd_t  cmd;
  pcmp_pkg::dp_stat_t stat;

  pcmp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  pcmp_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_BOXES  (MAX_BOXES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_tdata),
    .in_user   (s_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_user  (m_tuser)
  );

endmodule

`default_nettype wire

FILE: design/pcmp_checker.sv
// pcmp_checker: port-level assertions for the projector core, bound to the top level.
// Depends only on the top-level ports.
`default_nettype none

module pcmp_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_tvalid,
  input wire logic         s_tready,
  input wire logic [279:0] s_tdata,
  input wire logic [2:0]   s_tuser,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [191:0] m_tdata,
  input wire logic [2:0]   m_tuser,
  input wire logic         cfg_we,
  input wire logic [2:0]   cfg_index,
  input wire logic [27:0]  cfg_data
);

  // no output transaction right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output changed");

  // a kept point is lane or object
  a_class: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser[0] || m_tuser[1]))
    else $error("output without class");

  // map coordinates are zero without a pose
  a_map_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[2] |-> (m_tdata[191:96] == 96'd0))
    else $error("map fields set without pose");

  // one transaction in work at a time
  a_single: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken twice in a row");

endmodule

bind point_cloud_mask_projector_core pcmp_checker u_pcmp_checker (.*);

`default_nettype wire
